// File: rtl/assert_macros.svh
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Generic form: explicit clock and reset.
`define PCE_ASSERT(lbl, ck, rs, prop) \
  lbl: assert property (@(posedge ck) disable iff (rs) prop) \
    else $error("assertion failed");

// Uses the module's clk and rst.
`define PCE_ASSERT_CLK(lbl, prop) `PCE_ASSERT(lbl, clk, rst, prop)

`endif

// File: rtl/pce_pkg.sv
`default_nettype none

package pce_pkg;

  localparam int MAX_CRC_WIDTH_DEF = 32;
  localparam int DATA_W            = 8;
  localparam int OUT_W             = 32;
  localparam int CFG_IDX_W         = 3;
  localparam int CFG_DATA_W        = 32;
  localparam int QUEUE_DEPTH       = 2;

  localparam logic [1:0]  WIDTH_SEL_RST = 2'd1;
  localparam logic [31:0] POLY_RST      = 32'h0000_1002;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_WIDTH_SEL   = 3'd0,
    REG_POLY        = 3'd1,
    REG_REFLECT_IN  = 3'd2,
    REG_REFLECT_OUT = 3'd3,
    REG_INIT        = 3'd4,
    REG_FINAL_XOR   = 3'd5
  } cfg_reg_t;

  typedef struct packed {
    logic [DATA_W-1:0] data;
    logic              start;
    logic              finish;
  } item_t;

endpackage

`default_nettype wire

// File: rtl/pce_front.sv
`default_nettype none
`include "assert_macros.svh"

module pce_front (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        s_tvalid,
  output logic                             s_tready,
  input  wire logic [pce_pkg::DATA_W-1:0]  s_tdata,  // data_byte
  input  wire logic                        s_tlast,  // last_byte
  input  wire logic                        s_tuser,  // first_byte
  output logic                             q_valid,
  input  wire logic                        q_ready,
  output pce_pkg::item_t                   q_item
);

  pce_pkg::item_t mem [pce_pkg::QUEUE_DEPTH];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       push;
  logic       pop;

  assign s_tready = (count != 2'd2);
  assign q_valid  = (count != 2'd0);
  assign q_item   = mem[rd_ptr];
  assign push     = s_tvalid && s_tready;
  assign pop      = q_valid && q_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= '{data: s_tdata, start: s_tuser, finish: s_tlast};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      unique case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

  `PCE_ASSERT_CLK(a_ptr_count, (count != 2'd3) && ((count == 2'd1) == (wr_ptr != rd_ptr)))

endmodule

`default_nettype wire

// File: rtl/pce_back.sv
`default_nettype none
`include "assert_macros.svh"

module pce_back #(
  parameter int MAX_CRC_WIDTH = pce_pkg::MAX_CRC_WIDTH_DEF
) (
  input  wire logic                                   clk,
  input  wire logic                                   rst,
  input  wire logic [1:0]                             width_sel,
  input  wire logic [(MAX_CRC_WIDTH/8)*8-1:0]         poly,
  input  wire logic                                   rin,
  input  wire logic                                   rout,
  input  wire logic [(MAX_CRC_WIDTH/8)*8-1:0]         init,
  input  wire logic [(MAX_CRC_WIDTH/8)*8-1:0]         fxor,
  input  wire logic                                   q_valid,
  output logic                                        q_ready,
  input  wire pce_pkg::item_t                         q_item,
  output logic                                        m_tvalid,
  input  wire logic                                   m_tready,
  output logic [pce_pkg::OUT_W-1:0]                   m_tdata
);

  localparam int         CW   = (MAX_CRC_WIDTH / 8) * 8;
  localparam int         NB   = CW / 8;
  localparam int         OW   = pce_pkg::OUT_W;
  localparam logic [2:0] NB_C = 3'(NB);
  localparam logic [5:0] CW_C = 6'(CW);

  logic [CW-1:0] crc;
  logic [CW-1:0] crc_next;
  logic [CW-1:0] out_next;
  logic [CW-1:0] mask;
  logic [CW-1:0] top_mask;
  logic [CW-1:0] poly_m;
  logic [CW-1:0] rpoly;
  logic [CW-1:0] c;
  logic [CW-1:0] r;
  logic [2:0]    nb_sel;
  logic [2:0]    nb;
  logic [5:0]    msh;
  logic          pop;

  // reverse the low (CW - sh) bits
  function automatic logic [CW-1:0] mirror_w(input logic [CW-1:0] v, input logic [5:0] sh);
    logic [CW-1:0] t;
    for (int i = 0; i < CW; i++) begin
      t[i] = v[CW-1-i];
    end
    return t >> sh;
  endfunction

  assign q_ready = !q_item.finish || !m_tvalid || m_tready;
  assign pop     = q_valid && q_ready;

  always_comb begin
    nb_sel   = {1'b0, width_sel} + 3'd1;
    nb       = (nb_sel > NB_C) ? NB_C : nb_sel;
    msh      = CW_C - {nb, 3'b000};
    for (int b = 0; b < NB; b++) begin
      mask[8*b +: 8] = (3'(b) < nb) ? 8'hff : 8'h00;
    end
    top_mask = mask & ~(mask >> 1);
    poly_m   = poly & mask;
    rpoly    = mirror_w(poly_m, msh);

    if (q_item.start) begin
      c = rin ? mirror_w(init & mask, msh) : (init & mask);
    end else begin
      c = crc & mask;
    end

    if (rin) begin
      c = c ^ CW'(q_item.data);
      for (int k = 0; k < 8; k++) begin
        c = c[0] ? ((c >> 1) ^ rpoly) : (c >> 1);
      end
    end else begin
      c = c ^ (CW'(q_item.data) << {nb - 3'd1, 3'b000});
      for (int k = 0; k < 8; k++) begin
        c = (|(c & top_mask)) ? (((c << 1) ^ poly_m) & mask) : ((c << 1) & mask);
      end
    end

    crc_next = c & mask;
    r        = (rin != rout) ? mirror_w(crc_next, msh) : crc_next;
    out_next = (r ^ fxor) & mask;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      crc      <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (pop) crc <= crc_next;
      if (pop && q_item.finish) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop && q_item.finish) begin
      m_tdata <= OW'(out_next);
    end
  end

  `PCE_ASSERT_CLK(a_last_gives_result, pop && q_item.finish |=> m_tvalid)
  `PCE_ASSERT_CLK(a_pending_held, pop && !q_item.finish && m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))

endmodule

`default_nettype wire

// File: rtl/parameterized_crc_engine_top.sv
// Byte-wide CRC engine, widths 8/16/24/32, Rocksoft-style parameters.
// The last byte is stored in the queue; its result is then registered onto m_tdata.
// Throughput: one byte per cycle unless a finished result waits on m_tready; the back unit does an 8-step update.
// A 2-entry queue sits between input and update; the result is held in an output register.
// Reset (rst, sync): config to defaults, CRC register zero, queue and output empty.
`default_nettype none

module parameterized_crc_engine_top #(
  parameter int MAX_CRC_WIDTH = pce_pkg::MAX_CRC_WIDTH_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             cfg_wr_en,
  input  wire logic [pce_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [pce_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  input  wire logic                             s_tvalid,
  output logic                                  s_tready,
  input  wire logic [pce_pkg::DATA_W-1:0]       s_tdata,  // data_byte
  input  wire logic                             s_tlast,  // last_byte
  input  wire logic                             s_tuser,  // first_byte
  output logic                                  m_tvalid,
  input  wire logic                             m_tready,
  output logic [pce_pkg::OUT_W-1:0]             m_tdata   // crc_value
);

  localparam int CW = (MAX_CRC_WIDTH / 8) * 8;

  logic [1:0]     width_sel;
  logic [CW-1:0]  poly;
  logic           rin;
  logic           rout;
  logic [CW-1:0]  init;
  logic [CW-1:0]  fxor;

  logic           q_valid;
  logic           q_ready;
  pce_pkg::item_t q_item;

  always_ff @(posedge clk) begin
    if (rst) begin
      width_sel <= pce_pkg::WIDTH_SEL_RST;
      poly      <= pce_pkg::POLY_RST[CW-1:0];
      rin       <= 1'b0;
      rout      <= 1'b0;
      init      <= '0;
      fxor      <= '0;
    end else if (cfg_wr_en) begin
      unique case (pce_pkg::cfg_reg_t'(cfg_index))
        pce_pkg::REG_WIDTH_SEL:   width_sel <= cfg_wdata[1:0];
        pce_pkg::REG_POLY:        poly      <= cfg_wdata[CW-1:0];
        pce_pkg::REG_REFLECT_IN:  rin       <= cfg_wdata[0];
        pce_pkg::REG_REFLECT_OUT: rout      <= cfg_wdata[0];
        pce_pkg::REG_INIT:        init      <= cfg_wdata[CW-1:0];
        pce_pkg::REG_FINAL_XOR:   fxor      <= cfg_wdata[CW-1:0];
        default: ;
      endcase
    end
  end

  pce_front u_front (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .s_tuser  (s_tuser),
    .q_valid  (q_valid),
    .q_ready  (q_ready),
    .q_item   (q_item)
  );

  pce_back #(
    .MAX_CRC_WIDTH (MAX_CRC_WIDTH)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .width_sel (width_sel),
    .poly      (poly),
    .rin       (rin),
    .rout      (rout),
    .init      (init),
    .fxor      (fxor),
    .q_valid   (q_valid),
    .q_ready   (q_ready),
    .q_item    (q_item),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
  );

endmodule

`default_nettype wire

// File: bench/parameterized_crc_engine_top_test.sv
`default_nettype none

module parameterized_crc_engine_top_test;

  localparam int CRC_CAP       = ((pce_pkg::MAX_CRC_WIDTH_DEF & ~7) < 8) ? 8 :
                                 ((pce_pkg::MAX_CRC_WIDTH_DEF & ~7) > 32) ? 32 :
                                 (pce_pkg::MAX_CRC_WIDTH_DEF & ~7);
  localparam int PHASES        = 15;
  localparam int PHASE_BYTES   = 20;
  localparam int SETTLE_CYCLES = 8;
  localparam int RX_HOLD       = 200;
  localparam int STALL_LIMIT   = 5000;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              cfg_wr_en = 1'b0;
  logic [pce_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [pce_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;
  logic              s_tvalid = 1'b0;
  logic              s_tready;
  logic [pce_pkg::DATA_W-1:0] s_tdata = '0;   // data_byte
  logic              s_tlast = 1'b0; // last_byte
  logic              s_tuser = 1'b0; // first_byte
  logic              m_tvalid;
  logic              m_tready = 1'b0;
  logic [pce_pkg::OUT_W-1:0]  m_tdata;        // crc_value

  parameterized_crc_engine_top DUT (
    .clk(clk), .rst(rst),
    .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .s_tlast(s_tlast), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  // shadow configuration and CRC register
  logic [1:0]  sh_width_sel = pce_pkg::WIDTH_SEL_RST;
  logic [31:0] sh_poly      = pce_pkg::POLY_RST;
  logic        sh_refin     = 1'b0;
  logic        sh_refout    = 1'b0;
  logic [31:0] sh_init      = '0;
  logic [31:0] sh_xor       = '0;
  logic [31:0] crc_state    = '0;

  pce_pkg::item_t pending_bytes[$];
  logic [31:0]    crc_expected[$];

  int tx_idle = 33;
  int rx_idle = 73;
  bit rx_hold_req = 1'b0;
  int rx_hold_left = 0;
  int errors = 0;
  int bytes_queued = 0;
  int bytes_sent = 0;
  int crcs_checked = 0;
  int stall_count = 0;
  bit msg_open = 1'b0;

  initial forever #5 clk = ~clk;

  function automatic logic [31:0] reflect_bits(logic [31:0] v, int n);
    logic [31:0] r;
    r = '0;
    for (int k = 0; k < n; k++) begin
      r = (r << 1) | {31'b0, v[0]};
      v = v >> 1;
    end
    return r;
  endfunction

  function automatic void absorb_byte(pce_pkg::item_t it);
    int          w;
    logic [31:0] mask, poly, c, top, r;
    w = 8 * (int'(sh_width_sel) + 1);
    if (w > CRC_CAP) w = CRC_CAP;
    mask = 32'((33'h1 << w) - 33'h1);
    poly = sh_poly & mask;
    if (it.start) c = sh_refin ? reflect_bits(sh_init & mask, w) : (sh_init & mask);
    else c = crc_state & mask;
    if (sh_refin) begin
      poly = reflect_bits(poly, w);
      c = c ^ {24'b0, it.data};
      repeat (8) c = c[0] ? ((c >> 1) ^ poly) : (c >> 1);
    end else begin
      top = 32'h1 << (w - 1);
      c = c ^ ({24'b0, it.data} << (w - 8));
      repeat (8) c = ((c & top) != 0) ? (((c << 1) ^ poly) & mask) : ((c << 1) & mask);
    end
    c = c & mask;
    crc_state = c;
    if (it.finish) begin
      r = (sh_refin != sh_refout) ? reflect_bits(c, w) : c;
      crc_expected.push_back((r ^ sh_xor) & mask);
    end
  endfunction

  // byte stream driver
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        absorb_byte(pending_bytes.pop_front());
        bytes_sent++;
      end
      if (!(s_tvalid && !s_tready)) begin
        if (pending_bytes.size() > 0 && $urandom_range(99) >= tx_idle) begin
          s_tvalid <= 1'b1;
          s_tdata  <= pending_bytes[0].data;
          s_tuser  <= pending_bytes[0].start;
          s_tlast  <= pending_bytes[0].finish;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (crc_expected.size() == 0) begin
          $error("crc_value: no result expected, got %h", m_tdata);
          errors++;
        end else begin
          if (m_tdata !== crc_expected[0]) begin
            $error("crc_value: expected %h, actual %h", crc_expected[0], m_tdata);
            errors++;
          end
          void'(crc_expected.pop_front());
          crcs_checked++;
        end
      end
      if (rx_hold_req) begin
        rx_hold_req = 1'b0;
        rx_hold_left = RX_HOLD;
      end
      if (rx_hold_left > 0) begin
        rx_hold_left--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= ($urandom_range(99) >= rx_idle);
      end
    end
  end

  // watchdog on transfers
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_wr_en) begin
      stall_count <= 0;
    end else if (stall_count >= STALL_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end else begin
      stall_count <= stall_count + 1;
    end
  end

  task automatic push_byte(logic [7:0] d, logic f, logic l);
    pce_pkg::item_t it;
    it.data = d;
    it.start = f;
    it.finish = l;
    pending_bytes.push_back(it);
    bytes_queued++;
  endtask

  task automatic queue_message(int len, bit mark_first, bit mark_last);
    for (int i = 0; i < len; i++)
      push_byte(8'($urandom), mark_first && i == 0, mark_last && i == len - 1);
    msg_open = !mark_last;
  endtask

  task automatic drain();
    do @(negedge clk); while (pending_bytes.size() > 0 || crc_expected.size() > 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic cfg_write(pce_pkg::cfg_reg_t idx, logic [31:0] v);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= v;
    case (idx)
      pce_pkg::REG_WIDTH_SEL:   sh_width_sel = v[1:0];
      pce_pkg::REG_POLY:        sh_poly = v;
      pce_pkg::REG_REFLECT_IN:  sh_refin = v[0];
      pce_pkg::REG_REFLECT_OUT: sh_refout = v[0];
      pce_pkg::REG_INIT:        sh_init = v;
      pce_pkg::REG_FINAL_XOR:   sh_xor = v;
      default: ;
    endcase
  endtask

  task automatic apply_config(int p);
    logic [31:0] v[6];
    case (p)
      0: v = '{3, 32'h04C1_1DB7, 1, 1, 32'hFFFF_FFFF, 32'hFFFF_FFFF};
      1: v = '{0, 32'h07, 0, 0, 0, 0};
      2: v = '{2, 32'h0086_4CFB, 0, 0, 32'h00B7_04CE, 0};
      3: v = '{1, 32'h8005, 1, 0, 0, 32'hFFFF};
      4: v = '{3, 0, 0, 1, 32'hFFFF_FFFF, 0};
      5: v = '{0, 32'hFFFF_FFFF, 1, 1, 32'hFFFF_FFFF, 32'hFFFF_FFFF};
      6: v = '{3, 32'hFFFF_FFFF, 0, 0, 0, 0};
      7: v = '{1, 32'h1021, 0, 0, 32'hFFFF, 0};
      default: v = '{$urandom_range(3), $urandom, $urandom_range(1), $urandom_range(1),
                     $urandom, $urandom};
    endcase
    // random upper bits as well: the narrow fields must ignore them
    cfg_write(pce_pkg::REG_WIDTH_SEL, 32'({$urandom, 2'b00}) | v[0]);
    cfg_write(pce_pkg::REG_POLY, v[1]);
    cfg_write(pce_pkg::REG_REFLECT_IN, 32'({$urandom, 1'b0}) | v[2]);
    cfg_write(pce_pkg::REG_REFLECT_OUT, 32'({$urandom, 1'b0}) | v[3]);
    cfg_write(pce_pkg::REG_INIT, v[4]);
    cfg_write(pce_pkg::REG_FINAL_XOR, v[5]);
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  initial begin
    int start_count, roll, len;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // reset configuration; the first byte has no first mark and starts from the zero register
    push_byte(8'h00, 1'b0, 1'b0);
    push_byte(8'hFF, 1'b0, 1'b1);
    push_byte(8'hFF, 1'b1, 1'b1);
    push_byte(8'h00, 1'b1, 1'b1);
    push_byte(8'hA5, 1'b1, 1'b0);
    push_byte(8'h5A, 1'b0, 1'b0);
    push_byte(8'h3C, 1'b0, 1'b1);
    push_byte(8'h80, 1'b1, 1'b0);
    push_byte(8'h01, 1'b0, 1'b1);
    push_byte(8'h7F, 1'b0, 1'b1);
    push_byte(8'hFE, 1'b1, 1'b1);
    push_byte(8'h81, 1'b1, 1'b0);
    msg_open = 1'b1;
    drain();

    for (int p = 0; p < PHASES; p++) begin
      if (p < 5) begin
        tx_idle = 33; rx_idle = 73;
      end else if (p < 10) begin
        tx_idle = 73; rx_idle = 33;
      end else begin
        tx_idle = 0; rx_idle = 0;
      end
      apply_config(p);
      start_count = bytes_queued;
      if (msg_open) queue_message($urandom_range(1, 4), 1'b0, 1'b1);
      if (p == 11) begin
        // output side blocked while single-byte messages keep coming
        @(negedge clk);
        rx_hold_req = 1'b1;
        repeat (40) queue_message(1, 1'b1, 1'b1);
      end
      while (bytes_queued - start_count < PHASE_BYTES) begin
        roll = $urandom_range(99);
        len = ($urandom_range(9) == 0) ? $urandom_range(9, 24) : $urandom_range(1, 6);
        if (roll < 80) queue_message(len, 1'b1, 1'b1);
        else if (roll < 88) queue_message(len, 1'b0, 1'b1);
        else if (roll < 94) queue_message(len, 1'b1, 1'b0);
        else push_byte(8'($urandom), 1'($urandom), 1'($urandom));
      end
      if ($urandom_range(1) == 1) queue_message($urandom_range(1, 3), 1'b1, 1'b0);
      drain();
    end

    $display("Streamed %0d bytes over %0d configurations, checked %0d CRC values",
             bytes_sent, PHASES + 1, crcs_checked);
    $display("Widths 8..32, both reflections, open messages across config changes, stalls");
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

`default_nettype wire
